// ----- design/assert_macros.svh -----
// Assertion macros shared by the oscillator bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wtam_pkg.sv -----
// Shared types, constants and microcode ROM for the wavetable AM oscillator bank.
package wtam_pkg;

    localparam int TABLE_DEPTH      = 16384;
    localparam int OSCILLATOR_COUNT = 8;
    localparam int PHASE_BITS       = 32;

    localparam int TblAw   = $clog2(TABLE_DEPTH);
    localparam int ScaledW = PHASE_BITS + $clog2(TABLE_DEPTH + 1);
    localparam int VoiceW  = (OSCILLATOR_COUNT > 1) ? $clog2(OSCILLATOR_COUNT) : 1;

    localparam int InAddrW   = 14;
    localparam int SampleW   = 24;
    localparam int AmpW      = 23;
    localparam int FacW      = 30;
    localparam int ProdW     = SampleW + FacW;
    localparam int AccW      = ProdW + $clog2(OSCILLATOR_COUNT) + 1;
    localparam int FracShift = 28;

    localparam logic [AmpW-1:0] AM_BIAS_RESET = 23'd83886;

    localparam longint unsigned SampleRateCenti = 64'd4410000;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic                      enable;
        logic [InAddrW-1:0]        table_address;
        logic signed [SampleW-1:0] table_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SampleW-1:0] left_sample;
        logic signed [SampleW-1:0] right_sample;
    } out_item_t;

    // round(centi * 2^PHASE_BITS / 4410000), evaluated at elaboration
    function automatic logic [PHASE_BITS-1:0] phase_inc(input logic [15:0] centi);
        logic [63:0] num;
        num = (64'(centi) << PHASE_BITS) + (SampleRateCenti / 2);
        return PHASE_BITS'(num / SampleRateCenti);
    endfunction

    typedef logic [0:7][PHASE_BITS-1:0] inc_tab_t;

    localparam inc_tab_t CarIncTab = '{
        phase_inc(16'd3000),  phase_inc(16'd5500),  phase_inc(16'd8000),
        phase_inc(16'd11000), phase_inc(16'd14000), phase_inc(16'd16500),
        phase_inc(16'd18500), phase_inc(16'd19500)
    };

    localparam inc_tab_t ModIncTab = '{
        phase_inc(16'd1), phase_inc(16'd4), phase_inc(16'd2), phase_inc(16'd8),
        phase_inc(16'd1), phase_inc(16'd2), phase_inc(16'd4), phase_inc(16'd8)
    };

    // microcode
    localparam int UpcW = 3;

    localparam logic [UpcW-1:0] UPC_CAR0     = 3'd0;
    localparam logic [UpcW-1:0] UPC_MOD0     = 3'd1;
    localparam logic [UpcW-1:0] UPC_CAR      = 3'd2;
    localparam logic [UpcW-1:0] UPC_MOD      = 3'd3;
    localparam logic [UpcW-1:0] UPC_TAIL_FAC = 3'd4;
    localparam logic [UpcW-1:0] UPC_TAIL_MUL = 3'd5;
    localparam logic [UpcW-1:0] UPC_TAIL_ACC = 3'd6;
    localparam logic [UpcW-1:0] UPC_OUT      = 3'd7;

    typedef struct packed {
        logic            adv_car;    // step carrier phase, issue table read
        logic            adv_mod;    // step modulator phase, issue table read
        logic            lat_car;    // capture carrier word
        logic            lat_fac;    // capture modulator word + scaled offset
        logic            mul;        // product register
        logic            acc;        // add product into sum
        logic            clr;        // clear sum and product
        logic            inc_voice;
        logic            out_load;
        logic            branch;     // pick next step on last voice
        logic            done;
        logic            wait_out;   // hold until output slot frees
        logic [UpcW-1:0] tgt_taken;
        logic [UpcW-1:0] tgt_not;
    } ucw_t;

    function automatic ucw_t ucode(input logic [UpcW-1:0] upc);
        ucw_t w;
        w = '0;
        unique case (upc)
            UPC_CAR0: begin
                w.adv_car = 1'b1;
                w.clr     = 1'b1;
            end
            UPC_MOD0, UPC_MOD: begin
                w.adv_mod   = 1'b1;
                w.lat_car   = 1'b1;
                w.mul       = (upc == UPC_MOD);
                w.inc_voice = 1'b1;
                w.branch    = 1'b1;
                w.tgt_taken = UPC_TAIL_FAC;
                w.tgt_not   = UPC_CAR;
            end
            UPC_CAR: begin
                w.adv_car = 1'b1;
                w.lat_fac = 1'b1;
                w.acc     = 1'b1;
            end
            UPC_TAIL_FAC: begin
                w.lat_fac = 1'b1;
                w.acc     = 1'b1;
            end
            UPC_TAIL_MUL: begin
                w.mul = 1'b1;
            end
            UPC_TAIL_ACC: begin
                w.acc = 1'b1;
            end
            UPC_OUT: begin
                w.out_load = 1'b1;
                w.wait_out = 1'b1;
                w.done     = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/wtam_ram.sv -----
// Generic simple dual-port RAM with registered read.
module wtam_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/wtam_seq.sv -----
// Microcode sequencer: step counter, voice counter and ROM lookup.
`include "assert_macros.svh"

module wtam_seq
    import wtam_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_i,
    input  logic              out_free_i,
    output logic              busy_o,
    output ucw_t              ucw_o,
    output logic [VoiceW-1:0] voice_o
);

    logic              busy_reg, busy_next;
    logic [UpcW-1:0]   pc_reg, pc_next;
    logic [VoiceW-1:0] voice_reg, voice_next;
    ucw_t              word;
    logic              fire;
    logic              last;

    assign word = ucode(pc_reg);
    assign fire = busy_reg && !(word.wait_out && !out_free_i);
    assign last = (voice_reg == VoiceW'(OSCILLATOR_COUNT - 1));

    always_comb begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        voice_next = voice_reg;
        priority if (start_i) begin
            busy_next  = 1'b1;
            pc_next    = UPC_CAR0;
            voice_next = '0;
        end else if (fire) begin
            if (word.done) begin
                busy_next = 1'b0;
                pc_next   = UPC_CAR0;
            end else if (word.branch) begin
                pc_next = last ? word.tgt_taken : word.tgt_not;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
            if (word.inc_voice) begin
                voice_next = voice_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pc_reg    <= UPC_CAR0;
            voice_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            voice_reg <= voice_next;
        end
    end

    assign busy_o  = busy_reg;
    assign ucw_o   = fire ? word : '0;
    assign voice_o = voice_reg;

    `AST_IMPL(a_voice_range, busy_reg, {1'b0, voice_reg} < (VoiceW + 1)'(OSCILLATOR_COUNT), "voice index out of range")
    `AST_IMPL(a_start_idle, start_i, !busy_reg, "tick started while sequencer busy")

endmodule

// ----- design/wtam_dp.sv -----
// Datapath: phase accumulators, table index, AM multiply, mix, round and saturate.
module wtam_dp
    import wtam_pkg::*;
(
    input  logic              aclk,
    input  ucw_t              ucw_i,
    input  logic [VoiceW-1:0] voice_i,
    input  logic              clr_phase_i,
    input  logic [AmpW-1:0]   am_bias_i,
    input  logic [SampleW-1:0] rd_data_i,
    output logic [TblAw-1:0]  rd_addr_o,
    output out_item_t         result_o
);

    logic [PHASE_BITS-1:0]     car_phase_reg [OSCILLATOR_COUNT];
    logic [PHASE_BITS-1:0]     mod_phase_reg [OSCILLATOR_COUNT];
    logic [PHASE_BITS-1:0]     sel_phase, sel_inc, new_phase;
    logic [ScaledW-1:0]        scaled;
    logic signed [SampleW-1:0] car_reg;
    logic signed [FacW-1:0]    fac_reg, fac_next;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [AccW-1:0]    acc_reg;
    logic signed [AccW-1:0]    shifted;
    logic signed [SampleW-1:0] sample;
    out_item_t                 result_reg;

    // phase step and table index = phase * depth >> phase bits
    always_comb begin
        sel_phase = ucw_i.adv_car ? car_phase_reg[voice_i] : mod_phase_reg[voice_i];
        sel_inc   = ucw_i.adv_car ? CarIncTab[3'(voice_i)] : ModIncTab[3'(voice_i)];
        new_phase = sel_phase + sel_inc;
        scaled    = ScaledW'(new_phase) * ScaledW'(TABLE_DEPTH);
    end

    assign rd_addr_o = scaled[PHASE_BITS +: TblAw];

    // modulator word plus offset * 32
    assign fac_next = FacW'(signed'(rd_data_i)) + signed'({2'b00, am_bias_i, 5'b00000});

    always_ff @(posedge aclk) begin
        if (clr_phase_i) begin
            for (int i = 0; i < OSCILLATOR_COUNT; i++) begin
                car_phase_reg[i] <= '0;
                mod_phase_reg[i] <= '0;
            end
        end else if (ucw_i.adv_car) begin
            car_phase_reg[voice_i] <= new_phase;
        end else if (ucw_i.adv_mod) begin
            mod_phase_reg[voice_i] <= new_phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (ucw_i.lat_car) begin
            car_reg <= signed'(rd_data_i);
        end
        if (ucw_i.lat_fac) begin
            fac_reg <= fac_next;
        end
        if (ucw_i.clr) begin
            prod_reg <= '0;
        end else if (ucw_i.mul) begin
            prod_reg <= car_reg * fac_reg;
        end
        if (ucw_i.clr) begin
            acc_reg <= '0;
        end else if (ucw_i.acc) begin
            acc_reg <= acc_reg + AccW'(prod_reg);
        end
    end

    // round half up at 2^-28, then clamp to 24 bits
    always_comb begin
        shifted = (acc_reg + (AccW'(1) <<< (FracShift - 1))) >>> FracShift;
        if ((&shifted[AccW-1:SampleW-1]) || !(|shifted[AccW-1:SampleW-1])) begin
            sample = shifted[SampleW-1:0];
        end else if (shifted[AccW-1]) begin
            sample = {1'b1, {(SampleW - 1){1'b0}}};
        end else begin
            sample = {1'b0, {(SampleW - 1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ucw_i.out_load) begin
            result_reg.left_sample  <= sample;
            result_reg.right_sample <= sample;
        end
    end

    assign result_o = result_reg;

endmodule

// ----- design/wavetable_am_oscillator_bank_core.sv -----
// Top level of the wavetable AM oscillator bank: handshakes, config, table RAM.
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+------------------------------------
//  input    | s_valid s_ready s_data        | table write or sample tick
//  result   | m_valid m_ready m_data        | left/right mixed sample
//  config   | cfg_wr_en cfg_wr_data         | AM bias (unsigned Q0.23)
//
// A table write or a disabled tick does not start the sequencer. The first enabled
// tick clears all phases in that cycle and gives no sample. Each later enabled tick
// runs the microcode, which makes two table reads per voice on the single RAM read
// port.
// s_ready is low while the sequencer runs; a finished sample waits in the output
// register, and the final step stalls only if that register is still full.
// aresetn is synchronous; the wavetable contents are not reset.
`include "assert_macros.svh"

module wavetable_am_oscillator_bank_core
    import wtam_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data,
    input  logic            cfg_wr_en,
    input  logic [AmpW-1:0] cfg_wr_data
);

    logic              s_xfer;
    logic              tick_xfer;
    logic              start;
    logic              clr_phase;
    logic              busy;
    logic              out_free;
    logic              ram_we;
    logic [TblAw-1:0]  rd_addr;
    logic [SampleW-1:0] rd_data;
    ucw_t              ucw;
    logic [VoiceW-1:0] voice;

    logic              started_reg, started_next;
    logic              m_valid_reg, m_valid_next;
    logic [AmpW-1:0]   am_bias_reg, am_bias_next;

    assign s_ready = !busy;
    assign s_xfer  = s_valid && s_ready;

    // enabled tick: the first one only clears the phases
    assign tick_xfer = s_xfer && (s_data.operation == OP_TICK) && s_data.enable;
    assign start     = tick_xfer && started_reg;
    assign clr_phase = tick_xfer && !started_reg;

    // table writes land whatever enable says; out-of-range addresses drop
    assign ram_we = s_xfer && (s_data.operation == OP_WRITE)
                    && (32'(s_data.table_address) < 32'(TABLE_DEPTH));

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        started_next = started_reg || clr_phase;
        am_bias_next = cfg_wr_en ? cfg_wr_data : am_bias_reg;
        m_valid_next = m_valid_reg;
        if (ucw.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            am_bias_reg <= AM_BIAS_RESET;
        end else begin
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
            am_bias_reg <= am_bias_next;
        end
    end

    assign m_valid = m_valid_reg;

    wtam_ram #(
        .DATA_W (SampleW),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (TblAw'(s_data.table_address)),
        .wr_data (s_data.table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wtam_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start),
        .out_free_i (out_free),
        .busy_o     (busy),
        .ucw_o      (ucw),
        .voice_o    (voice)
    );

    wtam_dp u_dp (
        .aclk        (aclk),
        .ucw_i       (ucw),
        .voice_i     (voice),
        .clr_phase_i (clr_phase),
        .am_bias_i   (am_bias_reg),
        .rd_data_i   (rd_data),
        .rd_addr_o   (rd_addr),
        .result_o    (m_data)
    );

    // a sample only appears from the sequencer's output step
    `AST_IMPL(a_result_from_seq, $rose(m_valid_reg), $past(ucw.out_load), "sample without output step")
    // an output load never overwrites a sample that has not been taken
    `AST_IMPL(a_no_overwrite, ucw.out_load, out_free, "output register overwritten")

endmodule
